// File: hdl/isoc_pkg.sv
// Shared types and constants for the insertion sort unit with operation count.
package isoc_pkg;

  localparam int KEY_W          = 32;
  localparam int OP_W           = 12;
  localparam int STORE_SIZE_DEF = 64;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_value;
    logic                    last_in;
  } isoc_in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] sorted_value;
    logic                    last_out;
    logic [OP_W-1:0]         op_count;
    logic                    overflow;
  } isoc_out_t;

  // Data a cell hands to its upper neighbor.
  typedef struct packed {
    logic                    gt;
    logic                    occ;
    logic signed [KEY_W-1:0] key;
  } isoc_link_t;

  // Row-wide commands to every cell.
  typedef struct packed {
    logic ins;
    logic shift;
  } isoc_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DRAIN
  } isoc_state_e;

endpackage

// File: hdl/isoc_cell.sv
// One cell of the insertion chain: holds one key, inserts or shifts it out.
module isoc_cell import isoc_pkg::*; (
  input  logic                    clk_i,
  input  isoc_ctl_t               ctl_i,
  input  logic                    occ_i,
  input  logic signed [KEY_W-1:0] new_key_i,
  input  isoc_link_t              prev_i,
  input  logic signed [KEY_W-1:0] next_key_i,
  output isoc_link_t              link_o
);

  logic signed [KEY_W-1:0] key_q;
  logic signed [KEY_W-1:0] key_d;
  logic                    gt;
  logic                    take;

  assign gt   = occ_i && (key_q > new_key_i);
  assign take = gt || (!occ_i && prev_i.occ);

  always_comb begin
    priority if (ctl_i.shift) begin
      key_d = next_key_i;
    end else if (ctl_i.ins && take) begin
      key_d = prev_i.gt ? prev_i.key : new_key_i;
    end else begin
      key_d = key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign link_o.gt  = gt;
  assign link_o.occ = occ_i;
  assign link_o.key = key_q;

endmodule

// File: hdl/insertion_sort_with_op_count_unit.sv
// Top level of the insertion sort unit with operation count.
//
// Input channel: in_valid_i / in_stall_o / in_data_i carry one key word with a
// last marker. Output channel: out_valid_o / out_stall_i / out_data_o carry the
// sorted keys, each with the run's operation count and overflow flag.
// A word moves when valid is high and stall is low at a rising edge.
// Keys enter a chain of STORE_SIZE cells that compares the new key against
// every held key at once, so a key that is not last is taken every cycle.
// The shift count of each insertion is encoded and added in the cycle after it.
// After the word marked last, the input stalls in ST_CALC to settle the count,
// then the chain shifts the keys out from the low end, one word per cycle
// while the receiver does not stall; the first result is loaded into the
// output register in ST_DRAIN. The input is stalled until the final result
// has been loaded into the output register. Keys arriving with the store full
// are dropped and set the overflow flag. A receiver stall holds the output
// register and the chain. Reset empties the store and clears the count, the
// flag and the output valid.
module insertion_sort_with_op_count_unit import isoc_pkg::*; #(
  parameter int STORE_SIZE = STORE_SIZE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  isoc_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output isoc_out_t out_data_o
);

  localparam int CNT_W = $clog2(STORE_SIZE + 1);
  localparam int IDX_W = $clog2(STORE_SIZE);

  isoc_state_e state_q, state_d;

  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] fill_prev_q;
  logic [OP_W-1:0]  count_q, count_d;
  logic             dropped_q, dropped_d;
  logic             pend_q;
  logic [STORE_SIZE-1:0] edge_q;
  logic [STORE_SIZE-1:0] edge_d;
  logic [STORE_SIZE-1:0] occ;

  logic      acc;
  logic      full;
  logic      load;
  logic      clear_run;
  isoc_ctl_t ctl;

  logic             out_valid_q;
  isoc_out_t        out_q;

  logic [IDX_W-1:0] ins_idx;
  logic             ins_any;
  logic [CNT_W-1:0] shift_cnt;

  isoc_link_t              link      [STORE_SIZE];
  isoc_link_t              prev_link [STORE_SIZE];
  logic signed [KEY_W-1:0] next_key  [STORE_SIZE];

  assign full = (fill_q == CNT_W'(STORE_SIZE));
  assign load = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_data_i.last_in) state_d = ST_CALC;
      end
      ST_CALC: begin
        state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (load && fill_q == CNT_W'(1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall_o = 1'b1;
    ctl        = '0;
    clear_run  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        ctl.ins    = in_valid_i && !full;
      end
      ST_CALC: begin
      end
      ST_DRAIN: begin
        ctl.shift = load;
        clear_run = load && fill_q == CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign acc = in_valid_i && !in_stall_o;

  // Cell chain.
  for (genvar i = 0; i < STORE_SIZE; i++) begin : g_cell
    assign occ[i] = (CNT_W'(i) < fill_q);

    if (i == 0) begin : g_first
      assign prev_link[i] = '{gt: 1'b0, occ: 1'b1, key: '0};
    end else begin : g_mid
      assign prev_link[i] = link[i-1];
    end

    if (i == STORE_SIZE - 1) begin : g_top
      assign next_key[i] = '0;
    end else begin : g_low
      assign next_key[i] = link[i+1].key;
    end

    assign edge_d[i] = link[i].gt && !prev_link[i].gt;

    isoc_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .occ_i      (occ[i]),
      .new_key_i  (in_data_i.key_value),
      .prev_i     (prev_link[i]),
      .next_key_i (next_key[i]),
      .link_o     (link[i])
    );
  end

  // Insertion point of the previous key, from the one-hot edge.
  always_comb begin
    ins_idx = '0;
    for (int i = 0; i < STORE_SIZE; i++) begin
      if (edge_q[i]) ins_idx = ins_idx | IDX_W'(i);
    end
  end

  assign ins_any   = |edge_q;
  assign shift_cnt = ins_any ? (fill_prev_q - CNT_W'(ins_idx)) : '0;

  always_comb begin
    fill_d    = fill_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    if (ctl.ins) fill_d = fill_q + CNT_W'(1);
    if (ctl.shift) fill_d = fill_q - CNT_W'(1);
    if (pend_q) begin
      count_d = count_q + OP_W'(shift_cnt) + OP_W'(fill_prev_q != '0);
    end
    if (acc && full) dropped_d = 1'b1;
    if (clear_run) begin
      count_d   = '0;
      dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      pend_q    <= ctl.ins;
      if (ctl.shift) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.ins) begin
      edge_q      <= edge_d;
      fill_prev_q <= fill_q;
    end
    if (ctl.shift) begin
      out_q.sorted_value <= link[0].key;
      out_q.last_out     <= (fill_q == CNT_W'(1));
      out_q.op_count     <= count_q;
      out_q.overflow     <= dropped_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(STORE_SIZE))
    else $error("fill count beyond store size");

  a_edge_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $onehot0(edge_q))
    else $error("insertion point not unique");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && !clear_run) |=> $stable(count_q))
    else $error("count changed while draining");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q >= CNT_W'(2)) |-> (link[0].key <= link[1].key))
    else $error("lowest cells out of order");

endmodule

// File: verif/insertion_sort_with_op_count_unit_test.sv
// Testbench for the insertion sort unit: key runs checked against a local sort predictor.
module insertion_sort_with_op_count_unit_test;
  import isoc_pkg::*;

  localparam int DEPTH        = STORE_SIZE_DEF;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 250;
  localparam int KEY_TARGET   = 450;

  typedef logic signed [KEY_W-1:0] key_t;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  isoc_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  isoc_out_t out_data_o;

  insertion_sort_with_op_count_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // sort predictor state
  key_t            held_keys [DEPTH];
  int              held_count;
  logic [OP_W-1:0] op_total;
  logic            keys_dropped;
  isoc_out_t       sorted_words_q [$];

  bit sender_gaps = 1'b1;
  bit calm        = 1'b0;
  int hold_request;

  int error_count;
  int keys_sent;
  int runs_sent;
  int overflow_runs;
  int words_checked;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void insert_sorted_key(input key_t key, input logic is_last);
    int pos;
    isoc_out_t word;
    if (held_count >= DEPTH) begin
      keys_dropped = 1'b1;
    end else begin
      pos = held_count;
      while (pos > 0 && held_keys[pos-1] > key) begin
        held_keys[pos] = held_keys[pos-1];
        op_total++;
        pos--;
      end
      held_keys[pos] = key;
      if (held_count > 0) op_total++;
      held_count++;
    end
    if (is_last) begin
      for (int k = 0; k < held_count; k++) begin
        word.sorted_value = held_keys[k];
        word.last_out     = (k == held_count - 1);
        word.op_count     = op_total;
        word.overflow     = keys_dropped;
        sorted_words_q    = {sorted_words_q, word};
      end
      runs_sent++;
      if (keys_dropped) overflow_runs++;
      held_count   = 0;
      op_total     = '0;
      keys_dropped = 1'b0;
    end
  endfunction

  function automatic key_t rand_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0: return {1'b1, {(KEY_W-1){1'b0}}};
        1: return {1'b0, {(KEY_W-1){1'b1}}};
        2: return '0;
        3: return '1;
        default: return key_t'(1);
      endcase
    end
    if (r < 4) return key_t'(int'($urandom_range(0, 15)) - 8);
    return key_t'($urandom);
  endfunction

  task automatic send_word(input key_t key, input logic is_last);
    int gap;
    in_data_i  <= '{key_value: key, last_in: is_last};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    insert_sorted_key(key, is_last);
    keys_sent++;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) send_word(rand_key(), i == len - 1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sorted_words_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // result checker and receiver stall
  initial begin : sink
    int        stall_left;
    int        hold_left;
    logic      stall_next;
    isoc_out_t want;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (sorted_words_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_data_o));
        end else begin
          want = sorted_words_q.pop_front();
          words_checked++;
          if (out_data_o.sorted_value !== want.sorted_value)
            report_mismatch($sformatf("sorted_value got %0d expected %0d",
                                      out_data_o.sorted_value, want.sorted_value));
          if (out_data_o.last_out !== want.last_out)
            report_mismatch($sformatf("last_out got %b expected %b",
                                      out_data_o.last_out, want.last_out));
          if (out_data_o.op_count !== want.op_count)
            report_mismatch($sformatf("op_count got %0d expected %0d",
                                      out_data_o.op_count, want.op_count));
          if (out_data_o.overflow !== want.overflow)
            report_mismatch($sformatf("overflow got %b expected %b",
                                      out_data_o.overflow, want.overflow));
        end
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        stall_next = 1'b1;
        hold_left--;
      end else if (calm) begin
        stall_next = 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        stall_next = 1'b1;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = pick_gap();
        stall_next = (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end else begin
        stall_next = 1'b0;
      end
      out_stall_i <= stall_next;
    end
  end

  task automatic test_directed();
    send_word({1'b1, {(KEY_W-1){1'b0}}}, 1'b1);
    send_word({1'b0, {(KEY_W-1){1'b1}}}, 1'b1);
    send_word({1'b0, {(KEY_W-1){1'b1}}}, 1'b0);
    send_word({1'b1, {(KEY_W-1){1'b0}}}, 1'b0);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word('0, 1'b0);
    send_word(key_t'(1), 1'b1);
    for (int i = 0; i < 5; i++) send_word(key_t'(400 - 100 * i), i == 4);
    for (int i = 0; i < 4; i++) send_word(key_t'(i - 3), i == 3);
    for (int i = 0; i < 3; i++) send_word(key_t'(32'h0007_0000), i == 2);
    wait_drained();
  endtask

  // full store, then dropped keys including the one marked last, then a run that fills the store
  task automatic test_overflow();
    for (int i = 0; i < DEPTH; i++) send_word(key_t'(1000 - i), 1'b0);
    send_word(rand_key(), 1'b0);
    send_word(rand_key(), 1'b0);
    send_word(rand_key(), 1'b1);
    send_run(DEPTH);
    wait_drained();
  endtask

  task automatic test_backpressure();
    sender_gaps  = 1'b0;
    hold_request = HOLD_CYCLES;
    send_run(40);
    send_run(20);
    sender_gaps  = 1'b1;
    wait_drained();
  endtask

  task automatic test_no_gaps();
    calm = 1'b1;
    send_run(8);
    send_run(1);
    send_run(15);
    wait_drained();
    calm = 1'b0;
  endtask

  task automatic test_random_runs();
    int unsigned r;
    int len;
    while (keys_sent < KEY_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 12);
      else if (r < 93) len = $urandom_range(13, DEPTH);
      else len = $urandom_range(DEPTH + 1, DEPTH + 6);
      send_run(len);
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    held_count   = 0;
    op_total     = '0;
    keys_dropped = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_backpressure();
    test_no_gaps();
    test_random_runs();
    $display("Sent %0d keys in %0d runs, %0d of them overflowed the store.",
             keys_sent, runs_sent, overflow_runs);
    $display("Checked %0d sorted words under random gaps and a %0d-cycle output hold.",
             words_checked, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/isoc_pkg.sv
hdl/isoc_cell.sv
hdl/insertion_sort_with_op_count_unit.sv
verif/insertion_sort_with_op_count_unit_test.sv
